@@ sv/cng_pkg.sv @@
// ----------------------------------------------------------------------------
// cng_pkg
// Shared types and fixed constants of the colored noise generator.
// ----------------------------------------------------------------------------
package cng_pkg;

   // noise colour codes as written to the mode register
   typedef enum logic [1:0] {
      MODE_WHITE = 2'd0,
      MODE_BROWN = 2'd1,
      MODE_PINK  = 2'd2
   } noise_mode_type;

   localparam int WORD_W       = 16;
   localparam int SAMPLE_W     = 16;
   localparam int MODE_W       = 2;
   localparam int TAP_W        = 32;
   localparam int NUM_POLES    = 6;
   localparam int SUM_W        = TAP_W + 3;
   localparam int GAIN_W       = 13;
   localparam int SAMPLE_LIMIT = 30000;
   localparam int PINK_GAIN    = 3300;
   localparam int BROWN_SHIFT  = 6;
   localparam int BROWN_W      = SAMPLE_W + BROWN_SHIFT;

endpackage

@@ sv/colored_noise_generator.sv @@
// ----------------------------------------------------------------------------
// colored_noise_generator
// White, brown or pink noise samples from a stream of random words.
// ----------------------------------------------------------------------------
// One random word in gives one signed 16-bit sample out, one transaction per
// clock when the result side keeps up. The pipeline has four stages (input
// register, state update, pink sum, gain and clamp), and a word passes them in that
// order before its sample reaches the response stream. The throughput is
// set by the feedback stage, where each of the six filter poles and the brown
// integrator take one multiply-add per cycle. A stalled result side backs up
// the stages one at a time; empty stages keep accepting. Write the mode only
// while no transaction is in flight.
module colored_noise_generator #(
   parameter int FRAC_BITS = 24
) (
   input  logic                                clock,
   input  logic                                reset,
   // config
   input  logic                                csr_we,
   input  logic [cng_pkg::MODE_W-1:0]          csr_wdata,   // noise_mode
   // request stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [cng_pkg::WORD_W-1:0]          req_tdata,   // random_word
   input  logic                                req_tuser,   // clear_state
   // response stream
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [cng_pkg::SAMPLE_W-1:0] rsp_tdata    // sample
);

   localparam int CW  = FRAC_BITS + 2;                  // coefficient width
   localparam int NP  = cng_pkg::NUM_POLES;
   localparam int TW  = cng_pkg::TAP_W;
   localparam int PPW = TW + CW;                        // pole product width
   localparam int PTW = TW + 2;                         // pole term width
   localparam int FPW = cng_pkg::WORD_W + CW;           // feed product width
   localparam int FTW = FRAC_BITS + 3;                  // feed term width
   localparam int SW  = cng_pkg::SUM_W;
   localparam int GPW = SW + cng_pkg::GAIN_W;
   localparam int BW  = cng_pkg::BROWN_W;
   localparam int SMW = cng_pkg::SAMPLE_W;

   localparam logic signed [CW-1:0] POLE_COEF [NP] = '{
      CW'(((64'd99886 << FRAC_BITS) + 64'd50000) / 64'd100000),
      CW'(((64'd99332 << FRAC_BITS) + 64'd50000) / 64'd100000),
      CW'(((64'd969 << FRAC_BITS) + 64'd500) / 64'd1000),
      CW'(((64'd8665 << FRAC_BITS) + 64'd5000) / 64'd10000),
      CW'(((64'd55 << FRAC_BITS) + 64'd50) / 64'd100),
      CW'(-(((64'd7616 << FRAC_BITS) + 64'd5000) / 64'd10000))
   };
   localparam logic signed [CW-1:0] FEED_COEF [NP] = '{
      CW'(((64'd555179 << FRAC_BITS) + 64'd5000000) / 64'd10000000),
      CW'(((64'd750759 << FRAC_BITS) + 64'd5000000) / 64'd10000000),
      CW'(((64'd153852 << FRAC_BITS) + 64'd500000) / 64'd1000000),
      CW'(((64'd3104856 << FRAC_BITS) + 64'd5000000) / 64'd10000000),
      CW'(((64'd5329522 << FRAC_BITS) + 64'd5000000) / 64'd10000000),
      CW'(-(((64'd16898 << FRAC_BITS) + 64'd500000) / 64'd1000000))
   };
   localparam logic signed [CW-1:0] DIRECT_COEF =
      CW'(((64'd5362 << FRAC_BITS) + 64'd5000) / 64'd10000);
   localparam logic signed [CW-1:0] DELAY_COEF =
      CW'(((64'd115926 << FRAC_BITS) + 64'd500000) / 64'd1000000);

   localparam logic signed [GPW-1:0] ROUND_MASK = GPW'((64'd1 << FRAC_BITS) - 64'd1);
   localparam logic signed [GPW-1:0] LIMIT_G    = GPW'(cng_pkg::SAMPLE_LIMIT);
   localparam logic signed [BW-1:0]  LIMIT_B    = BW'(cng_pkg::SAMPLE_LIMIT);
   localparam logic signed [TW-1:0]  TAP_MAX    = {1'b0, {(TW-1){1'b1}}};
   localparam logic signed [TW-1:0]  TAP_MIN    = {1'b1, {(TW-1){1'b0}}};

   // configuration
   logic [cng_pkg::MODE_W-1:0] noise_mode_ff;

   // pipeline valids and handshakes
   logic in_valid_ff, s1_valid_ff, s2_valid_ff, out_valid_ff;
   logic in_ready, s1_ready, s2_ready, out_ready;
   logic in_move, s1_move, s2_move;

   // input stage
   logic [cng_pkg::WORD_W-1:0] in_word_ff;
   logic                       in_clear_ff;

   // filter state
   logic signed [SMW-1:0] brown_acc_ff, brown_acc_in;
   logic signed [TW-1:0]  pink_taps_ff [NP+1];
   logic signed [TW-1:0]  pink_taps_in [NP+1];

   // feedback stage logic
   logic signed [SMW-1:0] centered;
   logic signed [SMW-1:0] acc_src;
   logic signed [BW-1:0]  acc63, acc_div, brown_sum;
   logic signed [SMW-1:0] brown_new;
   logic signed [10:0]    brown_step;
   logic signed [TW-1:0]  tap_src [NP+1];
   logic signed [PPW-1:0] pole_prod [NP];
   logic signed [FPW-1:0] feed_prod [NP];
   logic signed [PTW-1:0] tap_sum [NP];
   logic signed [FPW-1:0] direct_prod, delay_prod;
   logic signed [FTW-1:0] direct_term, delay_term;
   logic signed [SMW-1:0] simple_sample;

   // stage 1 and 2 payload
   logic [cng_pkg::MODE_W-1:0] s1_mode_ff;
   logic signed [SMW-1:0]      s1_simple_ff;
   logic signed [FTW-1:0]      s1_direct_ff;
   logic signed [TW-1:0]       s1_tap6_ff;
   logic signed [SW-1:0]       pink_sum;
   logic                       s2_pink_ff;
   logic signed [SMW-1:0]      s2_simple_ff;
   logic signed [SW-1:0]       s2_sum_ff;

   // output stage logic
   logic signed [GPW-1:0] gain_prod, gain_quot;
   logic signed [SMW-1:0] pink_sample, out_sample;
   logic signed [SMW-1:0] out_data_ff;

   // ---------------------------------------------------------------- handshake
   assign out_ready  = !out_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || out_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign in_ready   = !in_valid_ff || s1_ready;
   assign in_move    = in_valid_ff && s1_ready;
   assign s1_move    = s1_valid_ff && s2_ready;
   assign s2_move    = s2_valid_ff && out_ready;
   assign req_tready = in_ready;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         noise_mode_ff <= cng_pkg::MODE_WHITE;
      end else if (csr_we) begin
         noise_mode_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_ready) begin
            in_valid_ff <= req_tvalid;
         end
         if (s1_ready) begin
            s1_valid_ff <= in_valid_ff;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_ready) begin
            out_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && in_ready) begin
         in_word_ff  <= req_tdata;
         in_clear_ff <= req_tuser;
      end
   end

   // ---------------------------------------------------------------- feedback
   always_comb begin
      // word - 32768 is the word with its top bit flipped
      centered = $signed({~in_word_ff[SMW-1], in_word_ff[SMW-2:0]});
      acc_src  = in_clear_ff ? '0 : brown_acc_ff;

      // acc * 63 / 64, truncated toward zero
      acc63   = (BW'(acc_src) <<< cng_pkg::BROWN_SHIFT) - BW'(acc_src);
      acc_div = (acc63 < 0) ? ((acc63 + BW'(63)) >>> cng_pkg::BROWN_SHIFT)
                            : (acc63 >>> cng_pkg::BROWN_SHIFT);
      brown_step = $signed({1'b0, in_word_ff[9:0]}) - 11'sd512;
      brown_sum  = acc_div + BW'(brown_step);
      if (brown_sum > LIMIT_B) begin
         brown_new = SMW'(LIMIT_B);
      end else if (brown_sum < -LIMIT_B) begin
         brown_new = SMW'(-LIMIT_B);
      end else begin
         brown_new = SMW'(brown_sum);
      end

      for (int k = 0; k <= NP; k++) begin
         tap_src[k] = in_clear_ff ? '0 : pink_taps_ff[k];
      end

      // (c * w) >> FRAC_BITS with w = x << (FRAC_BITS-15) is (c * x) >> 15
      for (int k = 0; k < NP; k++) begin
         pole_prod[k] = tap_src[k] * POLE_COEF[k];
         feed_prod[k] = centered * FEED_COEF[k];
         tap_sum[k]   = $signed(pole_prod[k][FRAC_BITS+PTW-1:FRAC_BITS])
                      + PTW'($signed(feed_prod[k][FPW-1:15]));
         if (tap_sum[k] > PTW'(TAP_MAX)) begin
            pink_taps_in[k] = TAP_MAX;
         end else if (tap_sum[k] < PTW'(TAP_MIN)) begin
            pink_taps_in[k] = TAP_MIN;
         end else begin
            pink_taps_in[k] = TW'(tap_sum[k]);
         end
      end
      direct_prod = centered * DIRECT_COEF;
      delay_prod  = centered * DELAY_COEF;
      direct_term = $signed(direct_prod[FPW-1:15]);
      delay_term  = $signed(delay_prod[FPW-1:15]);
      pink_taps_in[NP] = TW'(delay_term);

      brown_acc_in  = brown_new;
      simple_sample = '0;
      case (noise_mode_ff)
         cng_pkg::MODE_WHITE: begin
            simple_sample = centered;
         end
         cng_pkg::MODE_BROWN: begin
            simple_sample = brown_new;
         end
         default: begin
            simple_sample = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brown_acc_ff <= '0;
         for (int k = 0; k <= NP; k++) begin
            pink_taps_ff[k] <= '0;
         end
      end else if (in_move) begin
         brown_acc_ff <= (noise_mode_ff == cng_pkg::MODE_BROWN) ? brown_acc_in : acc_src;
         for (int k = 0; k <= NP; k++) begin
            pink_taps_ff[k] <= (noise_mode_ff == cng_pkg::MODE_PINK) ? pink_taps_in[k]
                                                                     : tap_src[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_move) begin
         s1_mode_ff   <= noise_mode_ff;
         s1_simple_ff <= simple_sample;
         s1_direct_ff <= direct_term;
         s1_tap6_ff   <= tap_src[NP];
      end
   end

   // ---------------------------------------------------------------- pink sum
   // the state taps still hold this transaction's new values while it sits here
   always_comb begin
      pink_sum = SW'(s1_direct_ff) + SW'(s1_tap6_ff);
      for (int k = 0; k < NP; k++) begin
         pink_sum = pink_sum + SW'(pink_taps_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_pink_ff   <= (s1_mode_ff == cng_pkg::MODE_PINK);
         s2_simple_ff <= s1_simple_ff;
         s2_sum_ff    <= pink_sum;
      end
   end

   // ---------------------------------------------------------------- gain, clamp
   always_comb begin
      gain_prod = s2_sum_ff * $signed(GPW'(cng_pkg::PINK_GAIN));
      gain_quot = (gain_prod < 0) ? ((gain_prod + ROUND_MASK) >>> FRAC_BITS)
                                  : (gain_prod >>> FRAC_BITS);
      if (gain_quot > LIMIT_G) begin
         pink_sample = SMW'(LIMIT_G);
      end else if (gain_quot < -LIMIT_G) begin
         pink_sample = SMW'(-LIMIT_G);
      end else begin
         pink_sample = SMW'(gain_quot);
      end
      out_sample = s2_pink_ff ? pink_sample : s2_simple_ff;
   end

   always_ff @(posedge clock) begin
      if (s2_move) begin
         out_data_ff <= out_sample;
      end
   end

   // ---------------------------------------------------------------- checks
   a_brown_bounded: assert property (@(posedge clock) disable iff (reset)
      (BW'(brown_acc_ff) <= LIMIT_B) && (BW'(brown_acc_ff) >= -LIMIT_B))
      else $error("brown integrator left its clamp range");

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (in_move && in_clear_ff && noise_mode_ff != cng_pkg::MODE_PINK
       && noise_mode_ff != cng_pkg::MODE_BROWN)
      |=> (brown_acc_ff == 0) && (pink_taps_ff[0] == 0) && (pink_taps_ff[1] == 0)
          && (pink_taps_ff[2] == 0) && (pink_taps_ff[3] == 0)
          && (pink_taps_ff[4] == 0) && (pink_taps_ff[5] == 0)
          && (pink_taps_ff[6] == 0))
      else $error("clear transaction left filter state nonzero");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && out_valid_ff && !rsp_tready)
      |=> s2_valid_ff && $stable(s2_sum_ff) && $stable(s2_simple_ff))
      else $error("stage two changed while the output was stalled");

   a_state_quiet: assert property (@(posedge clock) disable iff (reset)
      !in_move |=> $stable(brown_acc_ff) && $stable(pink_taps_ff[0])
                   && $stable(pink_taps_ff[6]))
      else $error("filter state moved without a transaction");

endmodule

@@ tb/sv/colored_noise_generator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// colored_noise_generator_tb
// Self-checking bench for the white, brown and pink noise generator.
// ----------------------------------------------------------------------------
// Random words go in on the request stream, with the clear flag in tuser.
// A behavioral copy of the integrator and the fixed-point pink filter
// predicts every sample, and each response transaction is compared with the
// oldest prediction. Directed tests cover word extremes, all four mode codes
// and clears across modes. Random traffic then mixes uniform runs with long biased
// stretches that drive both clamps, under three idle patterns on the two streams.
// ----------------------------------------------------------------------------
module colored_noise_generator_tb;

   localparam int FRAC_BITS   = 24;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 8;
   // mode code that selects no colour
   localparam logic [cng_pkg::MODE_W-1:0] MODE_SILENT = 2'd3;

   typedef enum int {
      BIAS_UNIFORM,
      BIAS_HIGH,
      BIAS_LOW
   } word_bias_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                csr_we = 1'b0;
   logic [cng_pkg::MODE_W-1:0]          csr_wdata = '0;
   logic                                req_tvalid = 1'b0;
   logic                                req_tready;
   logic [cng_pkg::WORD_W-1:0]          req_tdata = '0;   // random_word
   logic                                req_tuser = 1'b0; // clear_state
   logic                                rsp_tvalid;
   logic                                rsp_tready = 1'b0;
   logic signed [cng_pkg::SAMPLE_W-1:0] rsp_tdata;        // sample

   colored_noise_generator #(
      .FRAC_BITS(FRAC_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [cng_pkg::MODE_W-1:0] noise_mode_q = cng_pkg::MODE_WHITE;
   int                         brown_acc;
   int                         pink_tap [7];
   longint                     pole_coef [cng_pkg::NUM_POLES];
   longint                     feed_coef [cng_pkg::NUM_POLES];
   longint                     direct_coef;
   longint                     delay_coef;

   logic signed [cng_pkg::SAMPLE_W-1:0] expected_samples [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   function automatic longint round_coef(longint num, longint den);
      return ((num <<< FRAC_BITS) + den / 2) / den;
   endfunction

   function automatic longint floor_frac(longint x);
      return x >>> FRAC_BITS;
   endfunction

   function automatic int saturate_tap(longint x);
      if (x > 64'sd2147483647) return 32'h7FFFFFFF;
      if (x < -64'sd2147483648) return 32'h80000000;
      return int'(x);
   endfunction

   function automatic int clamp_sample(longint x);
      if (x > cng_pkg::SAMPLE_LIMIT) return cng_pkg::SAMPLE_LIMIT;
      if (x < -cng_pkg::SAMPLE_LIMIT) return -cng_pkg::SAMPLE_LIMIT;
      return int'(x);
   endfunction

   function automatic void clear_filters();
      brown_acc = 0;
      foreach (pink_tap[k]) pink_tap[k] = 0;
   endfunction

   function automatic int pink_sample(logic [cng_pkg::WORD_W-1:0] word);
      longint w;
      longint v;
      longint total;
      longint p;
      w = (longint'(word) - 32768) * (64'sd1 <<< (FRAC_BITS - 15));
      for (int k = 0; k < cng_pkg::NUM_POLES; k++) begin
         v = floor_frac(pole_coef[k] * longint'(pink_tap[k])) + floor_frac(feed_coef[k] * w);
         pink_tap[k] = saturate_tap(v);
      end
      // the delayed tap enters the sum before it is refreshed
      total = floor_frac(direct_coef * w);
      for (int k = 0; k < 7; k++) total += longint'(pink_tap[k]);
      pink_tap[6] = saturate_tap(floor_frac(delay_coef * w));
      p = total * cng_pkg::PINK_GAIN;
      p = (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
      return clamp_sample(p);
   endfunction

   function automatic logic signed [cng_pkg::SAMPLE_W-1:0] predict_sample(
      logic [cng_pkg::WORD_W-1:0] word, logic clr);
      int s;
      int r;
      int a;
      int wi;
      s = 0;
      wi = word;
      if (clr) clear_filters();
      if (noise_mode_q == cng_pkg::MODE_WHITE) begin
         s = wi - 32768;
      end else if (noise_mode_q == cng_pkg::MODE_BROWN) begin
         r = (wi & 32'h3FF) - 512;
         a = (brown_acc * 63) / 64 + r;
         brown_acc = clamp_sample(a);
         s = brown_acc;
      end else if (noise_mode_q == cng_pkg::MODE_PINK) begin
         s = pink_sample(word);
      end
      return s[cng_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic report_mismatch(string what, logic signed [cng_pkg::SAMPLE_W-1:0] want,
                                  logic signed [cng_pkg::SAMPLE_W-1:0] got);
      $display("mismatch %s: expected %0d got %0d at cycle %0d", what, want, got, cycle_count);
      mismatch_count++;
   endtask

   // one request transaction; returns just after the next falling edge
   task automatic send_word(logic [cng_pkg::WORD_W-1:0] word, logic clr);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= clr;
      do @(posedge clock); while (!req_tready);
      expected_samples.push_back(predict_sample(word, clr));
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_noise_mode(logic [cng_pkg::MODE_W-1:0] mode);
      wait_drained();
      csr_we    <= 1'b1;
      csr_wdata <= mode;
      @(negedge clock);
      csr_we <= 1'b0;
      noise_mode_q = mode;
   endtask

   function automatic logic [cng_pkg::WORD_W-1:0] make_word(word_bias_type bias);
      logic [cng_pkg::WORD_W-1:0] word;
      word = $urandom_range(65535);
      case (bias)
         BIAS_HIGH: word = word | 16'hFFF0;
         BIAS_LOW:  word = word & 16'h000F;
         default: ;
      endcase
      return word;
   endfunction

   task automatic test_white_extremes();
      write_noise_mode(cng_pkg::MODE_WHITE);
      send_word(16'h0000, 1'b0);
      send_word(16'hFFFF, 1'b0);
      send_word(16'h8000, 1'b1);
      send_word(16'h7FFF, 1'b0);
      send_word(16'h5555, 1'b0);
      send_word(16'hAAAA, 1'b1);
   endtask

   task automatic test_brown_steps();
      write_noise_mode(cng_pkg::MODE_BROWN);
      send_word(16'h03FF, 1'b0);
      send_word(16'h0000, 1'b0);
      send_word(16'hFC00, 1'b0);
      send_word(16'h03FF, 1'b1);
      send_word(16'h0200, 1'b0);
   endtask

   task automatic test_pink_steps();
      write_noise_mode(cng_pkg::MODE_PINK);
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0000, 1'b0);
      send_word(16'h8000, 1'b0);
      send_word(16'h7FFF, 1'b0);
      send_word(16'hFFFF, 1'b0);
   endtask

   task automatic test_silent_mode();
      // no colour: zero samples, state held apart from the clear
      write_noise_mode(MODE_SILENT);
      send_word(16'h1234, 1'b0);
      send_word(16'hFFFF, 1'b1);
      send_word(16'h0000, 1'b0);
      write_noise_mode(cng_pkg::MODE_BROWN);
      send_word(16'h03FF, 1'b0);
   endtask

   task automatic test_clear_across_modes();
      write_noise_mode(cng_pkg::MODE_PINK);
      send_word(16'hF000, 1'b0);
      write_noise_mode(cng_pkg::MODE_WHITE);
      send_word(16'h4321, 1'b1);
      write_noise_mode(cng_pkg::MODE_PINK);
      send_word(16'h8001, 1'b0);
      send_word(16'h0FFF, 1'b0);
   endtask

   task automatic test_random_traffic(int send_pct, int recv_pct, int item_budget);
      int sent;
      int run_len;
      int pick;
      word_bias_type bias;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      sent = 0;
      while (sent < item_budget) begin
         pick = $urandom_range(99);
         if (pick < 20) write_noise_mode(cng_pkg::MODE_WHITE);
         else if (pick < 55) write_noise_mode(cng_pkg::MODE_BROWN);
         else if (pick < 90) write_noise_mode(cng_pkg::MODE_PINK);
         else write_noise_mode(MODE_SILENT);
         pick = $urandom_range(2);
         bias = word_bias_type'(pick);
         // long biased stretches push the integrator and filter into the clamps
         run_len = (bias == BIAS_UNIFORM) ? $urandom_range(80, 10) : $urandom_range(250, 100);
         for (int k = 0; k < run_len && sent < item_budget; k++) begin
            send_word(make_word(bias), $urandom_range(99) < 2);
            sent++;
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      logic signed [cng_pkg::SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            report_mismatch("unexpected sample", '0, rsp_tdata);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_tdata !== want) report_mismatch("sample", want, rsp_tdata);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      pole_coef[0] = round_coef(99886, 100000);
      feed_coef[0] = round_coef(555179, 10000000);
      pole_coef[1] = round_coef(99332, 100000);
      feed_coef[1] = round_coef(750759, 10000000);
      pole_coef[2] = round_coef(969, 1000);
      feed_coef[2] = round_coef(153852, 1000000);
      pole_coef[3] = round_coef(8665, 10000);
      feed_coef[3] = round_coef(3104856, 10000000);
      pole_coef[4] = round_coef(55, 100);
      feed_coef[4] = round_coef(5329522, 10000000);
      pole_coef[5] = -round_coef(7616, 10000);
      feed_coef[5] = -round_coef(16898, 1000000);
      direct_coef  = round_coef(5362, 10000);
      delay_coef   = round_coef(115926, 1000000);
      clear_filters();
      noise_mode_q = cng_pkg::MODE_WHITE;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 37;
      recv_idle_pct = 80;
      test_white_extremes();
      test_brown_steps();
      test_pink_steps();
      test_silent_mode();
      test_clear_across_modes();

      test_random_traffic(37, 80, 270);
      test_random_traffic(80, 37, 270);
      test_random_traffic(0, 0, 270);

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (expected_samples.size() != 0) begin
         $display("mismatch: %0d samples never arrived", expected_samples.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

@@ files.f @@
sv/cng_pkg.sv
sv/colored_noise_generator.sv
tb/sv/colored_noise_generator_tb.sv
